### rtl/core/dlle_pkg.sv
// ---------------------------------------------------------------------------
// dlle_pkg: shared types and constants for the linked list engine
// Action and status codes, controller states and the command and status
// structs that join the controller to the datapath.
// ---------------------------------------------------------------------------
package dlle_pkg;

	localparam int MAX_NODES   = 64;
	localparam int TABLE_DEPTH = 64;
	localparam int HANDLE_W    = $clog2(TABLE_DEPTH);
	localparam int LINK_W      = HANDLE_W + 1;
	localparam int VALUE_W     = 32;
	localparam int ACTION_W    = 3;
	localparam int STATUS_W    = 2;

	// Link code of the sentinel head: top bit set
	localparam logic [LINK_W-1:0] HEAD_CODE = LINK_W'(TABLE_DEPTH);

	typedef enum logic [ACTION_W-1:0] {
		ACT_INS_AFTER  = 3'd0,
		ACT_INS_BEFORE = 3'd1,
		ACT_ERASE      = 3'd2,
		ACT_DUMP       = 3'd3,
		ACT_CLEAR      = 3'd4
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_DEAD  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		PK_STATUS,
		PK_INSERT,
		PK_NODE
	} push_kind_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_INS_W1,
		S_INS_W2,
		S_ERASE,
		S_DUMP_RD,
		S_DUMP_EMIT,
		S_RESP
	} state_t;

	typedef struct packed {
		logic       load;
		logic       rd_cur;
		logic       ins_w1;
		logic       ins_w2;
		logic       erase;
		logic       clear;
		logic       dump_start;
		logic       dump_adv;
		logic       push;
		push_kind_t push_kind;
		status_t    push_status;
	} dlle_cmd_t;

	typedef struct packed {
		action_t act;
		logic    at_head;
		logic    h_live;
		logic    table_full;
		logic    list_empty;
		logic    node_last;
		logic    out_free;
	} dlle_sts_t;

endpackage

### rtl/core/dlle_ram.sv
// ---------------------------------------------------------------------------
// dlle_ram: generic single write, single read RAM
// One write port and one read port, read data registered, no reset.
// ---------------------------------------------------------------------------
module dlle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, then register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/dlle_datapath.sv
// ---------------------------------------------------------------------------
// dlle_datapath: link tables, head links, live bits and result register
// Executes the controller's commands on the next, prev and value tables
// and reports the conditions the controller branches on.
// ---------------------------------------------------------------------------
module dlle_datapath import dlle_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dlle_cmd_t                  cmd,
	output dlle_sts_t                  sts,
	input  logic [ACTION_W-1:0]        action,
	input  logic                       anchor_is_head,
	input  logic [HANDLE_W-1:0]        anchor_handle,
	input  logic signed [VALUE_W-1:0]  item_value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [VALUE_W-1:0]  out_value,
	output logic [HANDLE_W-1:0]        out_handle,
	output logic [STATUS_W-1:0]        status,
	output logic                       last
);

	// Request registers
	action_t               act_q;
	logic                  at_head_q;
	logic [HANDLE_W-1:0]   h_q;
	logic [VALUE_W-1:0]    val_q;

	// List state
	logic [LINK_W-1:0]      alloc_q;
	logic [LINK_W-1:0]      head_next_q;
	logic [LINK_W-1:0]      head_prev_q;
	logic [TABLE_DEPTH-1:0] live_q;
	logic [LINK_W-1:0]      other_q;
	logic [HANDLE_W-1:0]    cur_q;
	logic [LINK_W-1:0]      cnt_q;

	// Result register
	logic                  out_valid_q;
	logic [VALUE_W-1:0]    out_value_q;
	logic [HANDLE_W-1:0]   out_handle_q;
	logic [STATUS_W-1:0]   out_status_q;
	logic                  out_last_q;

	// Table ports
	logic [HANDLE_W-1:0]   rd_addr;
	logic [LINK_W-1:0]     nxt_rd;
	logic [LINK_W-1:0]     prv_rd;
	logic [VALUE_W-1:0]    val_rd;
	logic                  nx_we;
	logic [LINK_W-1:0]     nx_tgt;
	logic [LINK_W-1:0]     nx_data;
	logic                  pv_we;
	logic [LINK_W-1:0]     pv_tgt;
	logic [LINK_W-1:0]     pv_data;

	logic                  after;
	logic [LINK_W-1:0]     anchor;
	logic [LINK_W-1:0]     fresh_code;
	logic [LINK_W-1:0]     other_w;
	logic                  out_free;

	assign after      = (act_q == ACT_INS_AFTER);
	assign anchor     = at_head_q ? HEAD_CODE : {1'b0, h_q};
	assign fresh_code = alloc_q;
	assign rd_addr    = cmd.rd_cur ? cur_q : h_q;
	assign out_free   = !out_valid_q || out_ready;

	// Neighbor of the anchor on the insert side
	always_comb begin
		if (at_head_q) begin
			other_w = after ? head_next_q : head_prev_q;
		end else begin
			other_w = after ? nxt_rd : prv_rd;
		end
	end

	// Select the link writes for each command
	always_comb begin
		nx_we   = 1'b0;
		nx_tgt  = fresh_code;
		nx_data = anchor;
		pv_we   = 1'b0;
		pv_tgt  = fresh_code;
		pv_data = anchor;
		if (cmd.ins_w1) begin
			nx_we   = 1'b1;
			nx_tgt  = fresh_code;
			nx_data = after ? other_w : anchor;
			pv_we   = 1'b1;
			pv_tgt  = fresh_code;
			pv_data = after ? anchor : other_w;
		end else if (cmd.ins_w2) begin
			nx_we   = 1'b1;
			nx_tgt  = after ? anchor : other_q;
			nx_data = fresh_code;
			pv_we   = 1'b1;
			pv_tgt  = after ? other_q : anchor;
			pv_data = fresh_code;
		end else if (cmd.erase) begin
			nx_we   = 1'b1;
			nx_tgt  = prv_rd;
			nx_data = nxt_rd;
			pv_we   = 1'b1;
			pv_tgt  = nxt_rd;
			pv_data = prv_rd;
		end
	end

	dlle_ram #(.WIDTH(LINK_W), .DEPTH(TABLE_DEPTH)) u_next_ram (
		.clk   (clk),
		.we    (nx_we && !nx_tgt[LINK_W-1]),
		.waddr (nx_tgt[HANDLE_W-1:0]),
		.wdata (nx_data),
		.raddr (rd_addr),
		.rdata (nxt_rd)
	);

	dlle_ram #(.WIDTH(LINK_W), .DEPTH(TABLE_DEPTH)) u_prev_ram (
		.clk   (clk),
		.we    (pv_we && !pv_tgt[LINK_W-1]),
		.waddr (pv_tgt[HANDLE_W-1:0]),
		.wdata (pv_data),
		.raddr (rd_addr),
		.rdata (prv_rd)
	);

	dlle_ram #(.WIDTH(VALUE_W), .DEPTH(TABLE_DEPTH)) u_value_ram (
		.clk   (clk),
		.we    (cmd.ins_w1),
		.waddr (fresh_code[HANDLE_W-1:0]),
		.wdata (val_q),
		.raddr (rd_addr),
		.rdata (val_rd)
	);

	// Capture the request and walk pointer
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q     <= action_t'(action);
			at_head_q <= anchor_is_head;
			h_q       <= anchor_handle;
			val_q     <= item_value;
		end
		if (cmd.ins_w1) begin
			other_q <= other_w;
		end
		if (cmd.dump_start) begin
			cur_q <= head_next_q[HANDLE_W-1:0];
			cnt_q <= '0;
		end else if (cmd.dump_adv) begin
			cur_q <= nxt_rd[HANDLE_W-1:0];
			cnt_q <= cnt_q + LINK_W'(1);
		end
	end

	// Update head links, live bits and allocation count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_q     <= '0;
			head_next_q <= HEAD_CODE;
			head_prev_q <= HEAD_CODE;
			live_q      <= '0;
		end else if (cmd.clear) begin
			alloc_q     <= '0;
			head_next_q <= HEAD_CODE;
			head_prev_q <= HEAD_CODE;
			live_q      <= '0;
		end else begin
			if (nx_we && nx_tgt[LINK_W-1]) begin
				head_next_q <= nx_data;
			end
			if (pv_we && pv_tgt[LINK_W-1]) begin
				head_prev_q <= pv_data;
			end
			if (cmd.ins_w1) begin
				live_q[fresh_code[HANDLE_W-1:0]] <= 1'b1;
			end
			if (cmd.erase) begin
				live_q[h_q] <= 1'b0;
			end
			if (cmd.push && cmd.push_kind == PK_INSERT) begin
				alloc_q <= alloc_q + LINK_W'(1);
			end
		end
	end

	// Hold a result until the consumer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			unique case (cmd.push_kind)
				PK_INSERT: begin
					out_value_q  <= '0;
					out_handle_q <= fresh_code[HANDLE_W-1:0];
					out_status_q <= ST_OK;
					out_last_q   <= 1'b1;
				end
				PK_NODE: begin
					out_value_q  <= val_rd;
					out_handle_q <= cur_q;
					out_status_q <= ST_OK;
					out_last_q   <= sts.node_last;
				end
				default: begin
					out_value_q  <= '0;
					out_handle_q <= '0;
					out_status_q <= cmd.push_status;
					out_last_q   <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign out_value  = out_value_q;
	assign out_handle = out_handle_q;
	assign status     = out_status_q;
	assign last       = out_last_q;

	// Report conditions to the controller
	always_comb begin
		sts.act        = act_q;
		sts.at_head    = at_head_q;
		sts.h_live     = ({1'b0, h_q} < LINK_W'(MAX_NODES)) && live_q[h_q];
		sts.table_full = (alloc_q >= LINK_W'(MAX_NODES));
		sts.list_empty = head_next_q[LINK_W-1];
		sts.node_last  = nxt_rd[LINK_W-1] || (cnt_q >= LINK_W'(MAX_NODES - 1));
		sts.out_free   = out_free;
	end

	a_alloc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		alloc_q <= LINK_W'(MAX_NODES))
		else $error("allocation count past table size");

	a_head_pair: assert property (@(posedge clk) disable iff (!arst_n)
		head_next_q[LINK_W-1] == head_prev_q[LINK_W-1])
		else $error("head links disagree on empty list");

	a_empty_after_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(live_q == '0) |-> head_next_q[LINK_W-1])
		else $error("list not empty with no live nodes");

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (!out_valid_q || out_ready))
		else $error("result pushed over a waiting result");

endmodule

### rtl/core/dlle_ctrl.sv
// ---------------------------------------------------------------------------
// dlle_ctrl: sequencing state machine for the linked list engine
// Decodes each request, steps the datapath through its table reads and
// writes, and pushes results into the result register.
// ---------------------------------------------------------------------------
module dlle_ctrl import dlle_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  dlle_sts_t sts,
	output dlle_cmd_t cmd
);

	state_t     state_q, state_d;
	status_t    st_q, st_d;
	push_kind_t kind_q, kind_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q    <= ST_OK;
			kind_q  <= PK_STATUS;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			kind_q  <= kind_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d         = state_q;
		st_d            = st_q;
		kind_d          = kind_q;
		cmd             = '0;
		cmd.push_kind   = PK_STATUS;
		cmd.push_status = ST_OK;
		in_ready        = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				kind_d = PK_STATUS;
				unique case (sts.act) inside
					ACT_INS_AFTER, ACT_INS_BEFORE: begin
						if (!sts.at_head && !sts.h_live) begin
							st_d    = ST_DEAD;
							state_d = S_RESP;
						end else if (sts.table_full) begin
							st_d    = ST_FULL;
							state_d = S_RESP;
						end else begin
							state_d = S_INS_W1;
						end
					end
					ACT_ERASE: begin
						if (sts.at_head || !sts.h_live) begin
							st_d    = ST_DEAD;
							state_d = S_RESP;
						end else begin
							state_d = S_ERASE;
						end
					end
					ACT_DUMP: begin
						if (sts.list_empty) begin
							st_d    = ST_EMPTY;
							state_d = S_RESP;
						end else begin
							cmd.dump_start = 1'b1;
							state_d        = S_DUMP_RD;
						end
					end
					ACT_CLEAR: begin
						cmd.clear = 1'b1;
						st_d      = ST_OK;
						state_d   = S_RESP;
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_INS_W1: begin
				cmd.ins_w1 = 1'b1;
				state_d    = S_INS_W2;
			end
			S_INS_W2: begin
				cmd.ins_w2 = 1'b1;
				kind_d     = PK_INSERT;
				st_d       = ST_OK;
				state_d    = S_RESP;
			end
			S_ERASE: begin
				cmd.erase = 1'b1;
				st_d      = ST_OK;
				state_d   = S_RESP;
			end
			S_DUMP_RD: begin
				cmd.rd_cur = 1'b1;
				state_d    = S_DUMP_EMIT;
			end
			S_DUMP_EMIT: begin
				cmd.rd_cur = 1'b1;
				if (sts.out_free) begin
					cmd.push      = 1'b1;
					cmd.push_kind = PK_NODE;
					if (sts.node_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.dump_adv = 1'b1;
						state_d      = S_DUMP_RD;
					end
				end
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.push        = 1'b1;
					cmd.push_kind   = kind_q;
					cmd.push_status = st_q;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	a_w2_after_w1: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_w2 |-> $past(cmd.ins_w1))
		else $error("second link write without first");

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_DECODE))
		else $error("accepted request not decoded");

	a_push_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> sts.out_free)
		else $error("push while the result register is busy");

endmodule

### rtl/core/doubly_linked_list_engine.sv
// ---------------------------------------------------------------------------
// doubly_linked_list_engine: circular doubly linked list with sentinel head
// An error or a clear goes from accept through S_DECODE to S_RESP; an erase
// adds S_ERASE and an insert adds S_INS_W1 and S_INS_W2. A dump emits each
// node through S_DUMP_RD and S_DUMP_EMIT, set by the registered read of the
// link table. One request at a time, and S_RESP and S_DUMP_EMIT stall while
// the result register is busy; a new request is taken while a result still waits.
// Reset clears the list, the live bits and the handle count at once.
// ---------------------------------------------------------------------------
module doubly_linked_list_engine import dlle_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [ACTION_W-1:0]        action,
	input  logic                       anchor_is_head,
	input  logic [HANDLE_W-1:0]        anchor_handle,
	input  logic signed [VALUE_W-1:0]  item_value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [VALUE_W-1:0]  out_value,
	output logic [HANDLE_W-1:0]        out_handle,
	output logic [STATUS_W-1:0]        status,
	output logic                       last
);

	dlle_cmd_t cmd;
	dlle_sts_t sts;

	dlle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dlle_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.action         (action),
		.anchor_is_head (anchor_is_head),
		.anchor_handle  (anchor_handle),
		.item_value     (item_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_value      (out_value),
		.out_handle     (out_handle),
		.status         (status),
		.last           (last)
	);

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: request/result checks for the doubly linked list engine
// Drives insert, erase, dump and clear requests, keeps a shadow copy of the
// link tables, and compares every result field with the shadow's answer.
// Covers the empty list, the full table, dead anchors, spare action codes,
// back-pressure from the result side and random idling on both sides.
// ---------------------------------------------------------------------------
module testbench;
	import dlle_pkg::*;

	localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd5;
	localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;
	localparam int RANDOM_REQS   = 50;
	localparam int TAIL_REQS     = 30;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 20;
	localparam int MAX_ERR_LINES = 40;

	typedef struct {
		logic signed [VALUE_W-1:0] value;
		logic [HANDLE_W-1:0]       handle;
		status_t                   st;
		logic                      fin;
	} reply_t;

	logic                      clk            = 1'b0;
	logic                      arst_n         = 1'b0;
	logic                      in_valid       = 1'b0;
	logic                      in_ready;
	logic [ACTION_W-1:0]       action         = '0;
	logic                      anchor_is_head = 1'b0;
	logic [HANDLE_W-1:0]       anchor_handle  = '0;
	logic signed [VALUE_W-1:0] item_value     = '0;
	logic                      out_valid;
	logic                      out_ready      = 1'b0;
	logic signed [VALUE_W-1:0] out_value;
	logic [HANDLE_W-1:0]       out_handle;
	logic [STATUS_W-1:0]       status;
	logic                      last;

	doubly_linked_list_engine dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.action         (action),
		.anchor_is_head (anchor_is_head),
		.anchor_handle  (anchor_handle),
		.item_value     (item_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_value      (out_value),
		.out_handle     (out_handle),
		.status         (status),
		.last           (last)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow list state
	logic [LINK_W-1:0]         nxt  [TABLE_DEPTH];
	logic [LINK_W-1:0]         prv  [TABLE_DEPTH];
	logic signed [VALUE_W-1:0] vals [TABLE_DEPTH];
	bit                        live [TABLE_DEPTH];
	int                        used    = 0;
	logic [LINK_W-1:0]         hd_next = HEAD_CODE;
	logic [LINK_W-1:0]         hd_prev = HEAD_CODE;

	reply_t reply_q [$];

	// Run bookkeeping
	int  fail_count   = 0;
	int  reqs_sent    = 0;
	int  replies_seen = 0;
	int  n_full       = 0;
	int  n_dead       = 0;
	int  n_empty      = 0;
	bit  tx_gaps      = 1'b1;
	bit  tx_calm      = 1'b0;
	bit  rx_gaps      = 1'b1;
	bit  rx_calm      = 1'b0;
	int  hold_req     = 0;
	int  hold_seen    = 0;
	int  hold_left    = 0;
	int  stall_left   = 0;

	function automatic logic [LINK_W-1:0] link_after(logic [LINK_W-1:0] code);
		return code[HANDLE_W] ? hd_next : nxt[code[HANDLE_W-1:0]];
	endfunction

	function automatic logic [LINK_W-1:0] link_before(logic [LINK_W-1:0] code);
		return code[HANDLE_W] ? hd_prev : prv[code[HANDLE_W-1:0]];
	endfunction

	function automatic void tie_after(logic [LINK_W-1:0] code, logic [LINK_W-1:0] to);
		if (code[HANDLE_W]) hd_next = to;
		else nxt[code[HANDLE_W-1:0]] = to;
	endfunction

	function automatic void tie_before(logic [LINK_W-1:0] code, logic [LINK_W-1:0] to);
		if (code[HANDLE_W]) hd_prev = to;
		else prv[code[HANDLE_W-1:0]] = to;
	endfunction

	function automatic void push_reply(logic signed [VALUE_W-1:0] v,
			logic [HANDLE_W-1:0] hd, status_t s, logic f);
		reply_t r;
		r.value  = v;
		r.handle = hd;
		r.st     = s;
		r.fin    = f;
		reply_q.push_back(r);
		if (s == ST_FULL) n_full++;
		if (s == ST_DEAD) n_dead++;
		if (s == ST_EMPTY) n_empty++;
	endfunction

	// Apply one request to the shadow list and queue the results it causes
	function automatic void list_update(logic [ACTION_W-1:0] act, logic at_head,
			logic [HANDLE_W-1:0] h, logic signed [VALUE_W-1:0] val);
		logic [LINK_W-1:0]   anchor;
		logic [LINK_W-1:0]   other;
		logic [LINK_W-1:0]   cur;
		logic [LINK_W-1:0]   nx;
		logic [LINK_W-1:0]   p;
		logic [LINK_W-1:0]   q;
		logic [HANDLE_W-1:0] n;
		case (act)
			ACT_INS_AFTER, ACT_INS_BEFORE: begin
				// dead anchor wins over a full table
				if (!at_head && !live[h]) begin
					push_reply('0, '0, ST_DEAD, 1'b1);
				end else if (used >= MAX_NODES) begin
					push_reply('0, '0, ST_FULL, 1'b1);
				end else begin
					anchor  = at_head ? HEAD_CODE : {1'b0, h};
					n       = used[HANDLE_W-1:0];
					vals[n] = val;
					live[n] = 1'b1;
					if (act == ACT_INS_AFTER) begin
						other  = link_after(anchor);
						nxt[n] = other;
						prv[n] = anchor;
						tie_after(anchor, {1'b0, n});
						tie_before(other, {1'b0, n});
					end else begin
						other  = link_before(anchor);
						prv[n] = other;
						nxt[n] = anchor;
						tie_before(anchor, {1'b0, n});
						tie_after(other, {1'b0, n});
					end
					used++;
					push_reply('0, n, ST_OK, 1'b1);
				end
			end
			ACT_ERASE: begin
				if (at_head || !live[h]) begin
					push_reply('0, '0, ST_DEAD, 1'b1);
				end else begin
					p = prv[h];
					q = nxt[h];
					tie_after(p, q);
					tie_before(q, p);
					live[h] = 1'b0;
					push_reply('0, '0, ST_OK, 1'b1);
				end
			end
			ACT_DUMP: begin
				cur = hd_next;
				if (cur[HANDLE_W]) begin
					push_reply('0, '0, ST_EMPTY, 1'b1);
				end else begin
					for (int k = 0; k < MAX_NODES; k++) begin
						if (cur[HANDLE_W]) break;
						nx = nxt[cur[HANDLE_W-1:0]];
						push_reply(vals[cur[HANDLE_W-1:0]], cur[HANDLE_W-1:0], ST_OK,
							nx[HANDLE_W] || (k + 1 >= MAX_NODES));
						cur = nx;
					end
				end
			end
			ACT_CLEAR: begin
				for (int i = 0; i < TABLE_DEPTH; i++) live[i] = 1'b0;
				used    = 0;
				hd_next = HEAD_CODE;
				hd_prev = HEAD_CODE;
				push_reply('0, '0, ST_OK, 1'b1);
			end
			default: ;
		endcase
	endfunction

	function automatic int pick_live();
		int hs [$];
		for (int i = 0; i < TABLE_DEPTH; i++) if (live[i]) hs.push_back(i);
		if (hs.size() == 0) return -1;
		return hs[$urandom_range(0, hs.size() - 1)];
	endfunction

	function automatic int pick_dead();
		int hs [$];
		for (int i = 0; i < TABLE_DEPTH; i++) if (!live[i]) hs.push_back(i);
		if (hs.size() == 0) return -1;
		return hs[$urandom_range(0, hs.size() - 1)];
	endfunction

	function automatic logic signed [VALUE_W-1:0] rand_value();
		case ($urandom_range(0, 7))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7fff_ffff;
			2:       return -32'sd1;
			3:       return '0;
			default: return $urandom;
		endcase
	endfunction

	// Offer one request, with an optional idle burst ahead of it
	task automatic send_req(logic [ACTION_W-1:0] act, logic at_head,
			logic [HANDLE_W-1:0] h, logic signed [VALUE_W-1:0] val);
		int gap;
		gap = 0;
		if ($urandom_range(0, 15) == 0) tx_calm = !tx_calm;
		if (tx_gaps && !tx_calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 7);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid       <= 1'b1;
		action         <= act;
		anchor_is_head <= at_head;
		anchor_handle  <= h;
		item_value     <= val;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		list_update(act, at_head, h, val);
		reqs_sent++;
	endtask

	// Drop valid and wait until every queued result has come back
	task automatic await_replies();
		@(negedge clk);
		in_valid <= 1'b0;
		while (reply_q.size() != 0) @(posedge clk);
	endtask

	// Weighted random request: mostly well-formed list edits, some noise
	task automatic send_random_req(output bit counted);
		int                  pick;
		int                  h;
		int                  dh;
		logic                at_head;
		logic [ACTION_W-1:0] act;
		pick    = $urandom_range(0, 99);
		h       = pick_live();
		dh      = pick_dead();
		at_head = (h < 0) || ($urandom_range(0, 3) == 0);
		counted = 1'b1;
		if (pick < 40) begin
			act = (pick < 22) ? ACT_INS_AFTER : ACT_INS_BEFORE;
			send_req(act, at_head, at_head ? HANDLE_W'($urandom) : h[HANDLE_W-1:0],
				rand_value());
		end else if (pick < 62) begin
			if (h < 0) send_req(ACT_INS_AFTER, 1'b1, HANDLE_W'($urandom), rand_value());
			else send_req(ACT_ERASE, 1'b0, h[HANDLE_W-1:0], rand_value());
		end else if (pick < 69) begin
			send_req(ACT_DUMP, 1'($urandom_range(0, 1)), HANDLE_W'($urandom), rand_value());
		end else if (pick < 72) begin
			send_req(ACT_CLEAR, 1'($urandom_range(0, 1)), HANDLE_W'($urandom),
				rand_value());
		end else if (pick < 80) begin
			act = $urandom_range(0, 1) ? ACT_INS_AFTER : ACT_INS_BEFORE;
			if (dh < 0) send_req(act, 1'b1, HANDLE_W'($urandom), rand_value());
			else send_req(act, 1'b0, dh[HANDLE_W-1:0], rand_value());
		end else if (pick < 86) begin
			if (dh < 0 || $urandom_range(0, 1) == 0)
				send_req(ACT_ERASE, 1'b1, HANDLE_W'($urandom), rand_value());
			else
				send_req(ACT_ERASE, 1'b0, dh[HANDLE_W-1:0], rand_value());
		end else if (pick < 90) begin
			counted = 1'b0;
			send_req(ACTION_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)),
				1'($urandom_range(0, 1)), HANDLE_W'($urandom), $urandom);
		end else begin
			act     = ACTION_W'($urandom_range(0, ACT_SPARE_HI));
			counted = (act <= ACT_CLEAR);
			send_req(act, 1'($urandom_range(0, 1)), HANDLE_W'($urandom), $urandom);
		end
	endtask

	// Edge cases on a small list, spare codes and clear
	task automatic test_directed();
		send_req(ACT_DUMP, 1'b0, 6'd0, '0);
		send_req(ACT_ERASE, 1'b1, 6'd0, '0);
		send_req(ACT_ERASE, 1'b0, 6'd0, '0);
		send_req(ACT_INS_AFTER, 1'b0, 6'd5, 32'sd7);
		send_req(ACT_INS_AFTER, 1'b1, 6'd0, 32'sh8000_0000);
		send_req(ACT_INS_BEFORE, 1'b1, 6'd63, 32'sh7fff_ffff);
		send_req(ACT_INS_AFTER, 1'b0, 6'd0, '0);
		send_req(ACT_INS_BEFORE, 1'b0, 6'd1, -32'sd1);
		send_req(ACT_INS_BEFORE, 1'b0, 6'd63, 32'sd1);
		send_req(ACT_DUMP, 1'b1, 6'd63, -32'sd1);
		send_req(ACT_ERASE, 1'b0, 6'd2, '0);
		send_req(ACT_ERASE, 1'b0, 6'd2, '0);
		send_req(ACT_ERASE, 1'b0, 6'd0, '0);
		send_req(ACT_ERASE, 1'b0, 6'd1, '0);
		send_req(ACT_DUMP, 1'b0, 6'd0, '0);
		send_req(ACT_SPARE_LO, 1'b1, 6'd63, -32'sd1);
		send_req(ACT_SPARE_LO + 3'd1, 1'b0, 6'd0, '0);
		send_req(ACT_SPARE_HI, 1'b1, 6'd21, 32'sh5555_5555);
		send_req(ACT_CLEAR, 1'b0, 6'd0, '0);
		send_req(ACT_DUMP, 1'b0, 6'd0, '0);
		send_req(ACT_INS_AFTER, 1'b0, 6'd0, 32'sd3);
		send_req(ACT_INS_BEFORE, 1'b1, 6'd42, 32'sh2aaa_aaaa);
		send_req(ACT_ERASE, 1'b0, 6'd0, '0);
		send_req(ACT_DUMP, 1'b0, 6'd0, '0);
		await_replies();
	endtask

	// Fill every slot, hit the full table, and dump all nodes under back-pressure
	task automatic test_full_table();
		int                  h;
		logic                at_head;
		logic [ACTION_W-1:0] act;
		send_req(ACT_CLEAR, 1'b0, 6'd0, '0);
		for (int i = 0; i < MAX_NODES; i++) begin
			h       = pick_live();
			at_head = (h < 0) || ($urandom_range(0, 4) == 0);
			act     = $urandom_range(0, 1) ? ACT_INS_AFTER : ACT_INS_BEFORE;
			send_req(act, at_head, at_head ? HANDLE_W'($urandom) : h[HANDLE_W-1:0],
				rand_value());
		end
		send_req(ACT_INS_AFTER, 1'b1, 6'd0, 32'sd9);
		send_req(ACT_INS_BEFORE, 1'b0, 6'd63, 32'sd9);
		await_replies();

		// hold the result side while requests keep coming
		hold_req++;
		send_req(ACT_DUMP, 1'b0, 6'd0, '0);
		send_req(ACT_INS_AFTER, 1'b1, 6'd0, 32'sd1);
		send_req(ACT_ERASE, 1'b0, 6'd10, '0);
		send_req(ACT_INS_BEFORE, 1'b0, 6'd10, 32'sd2);
		send_req(ACT_ERASE, 1'b0, 6'd10, '0);
		send_req(ACT_INS_AFTER, 1'b1, 6'd0, 32'sd3);
		send_req(ACT_DUMP, 1'b0, 6'd0, '0);
		await_replies();
	endtask

	task automatic test_random();
		int cnt;
		bit counted;
		cnt = 0;
		while (cnt < RANDOM_REQS) begin
			send_random_req(counted);
			if (counted) cnt++;
		end
		await_replies();
	endtask

	// Closing stretch with no idling on either side
	task automatic test_quiet_tail();
		int cnt;
		bit counted;
		cnt     = 0;
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		while (cnt < TAIL_REQS) begin
			send_random_req(counted);
			if (counted) cnt++;
		end
	endtask

	// Result-side ready: long holds on request, random stall bursts otherwise
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (!rx_gaps || rx_calm) begin
			stall_left = 0;
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 6);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic report(string what, longint want, longint got);
		fail_count++;
		if (fail_count <= MAX_ERR_LINES)
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
	endtask

	// Compare each accepted result with the oldest queued one
	always @(posedge clk) begin : check_replies
		reply_t want;
		if (arst_n && out_valid && out_ready) begin
			replies_seen++;
			if (reply_q.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_ERR_LINES)
					$display("%0t: result with none pending: expected none, actual %0d/%0d/%0d/%0d",
						$time, out_value, out_handle, status, last);
			end else begin
				want = reply_q.pop_front();
				if (out_value !== want.value) report("value", want.value, out_value);
				if (out_handle !== want.handle) report("handle", want.handle, out_handle);
				if (status !== want.st) report("status", want.st, status);
				if (last !== want.fin) report("last", want.fin, last);
			end
		end
	end

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_full_table();
		test_random();
		test_quiet_tail();
		await_replies();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d requests and %0d results over inserts, erases, dumps, clears",
			reqs_sent, replies_seen);
		$display("including %0d full-table, %0d dead-anchor and %0d empty-list answers",
			n_full, n_dead, n_empty);
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

### filelist.f
rtl/core/dlle_pkg.sv
rtl/core/dlle_ram.sv
rtl/core/dlle_datapath.sv
rtl/core/dlle_ctrl.sv
rtl/core/doubly_linked_list_engine.sv
dv/testbench.sv
